// File: hw/rtl/y64_pkg.sv
// Shared constants and types for the Y86-64 executor.
`default_nettype none
package y64_pkg;
   localparam int MemBytes = 4096;
   localparam int AddrBits = 12;

   localparam logic [1:0] FUNC_WR_MEM  = 2'd0;
   localparam logic [1:0] FUNC_RD_MEM  = 2'd1;
   localparam logic [1:0] FUNC_EXEC    = 2'd2;
   localparam logic [1:0] FUNC_RD_REG  = 2'd3;

   localparam logic [1:0] ST_AOK = 2'd0;
   localparam logic [1:0] ST_HLT = 2'd1;
   localparam logic [1:0] ST_ADR = 2'd2;
   localparam logic [1:0] ST_INS = 2'd3;

   localparam logic [3:0] NO_REG = 4'd15;
   localparam logic [3:0] SP_REG = 4'd4;

   localparam logic [3:0] I_HALT   = 4'h0;
   localparam logic [3:0] I_NOP    = 4'h1;
   localparam logic [3:0] I_CMOV   = 4'h2;
   localparam logic [3:0] I_IRMOV  = 4'h3;
   localparam logic [3:0] I_RMMOV  = 4'h4;
   localparam logic [3:0] I_MRMOV  = 4'h5;
   localparam logic [3:0] I_OP     = 4'h6;
   localparam logic [3:0] I_JXX    = 4'h7;
   localparam logic [3:0] I_CALL   = 4'h8;
   localparam logic [3:0] I_RET    = 4'h9;
   localparam logic [3:0] I_PUSH   = 4'hA;
   localparam logic [3:0] I_POP    = 4'hB;

   // memory port request from the sequencer
   typedef struct packed {
      logic                wr;
      logic [AddrBits-1:0] addr;
      logic [7:0]          wdata;
   } mem_req_type;

   // true when an 8-byte access at a fits in memory
   function automatic logic fits8(input logic [63:0] a);
      fits8 = (a <= 64'(MemBytes - 8));
   endfunction

   // true when a single byte address is in memory
   function automatic logic fits1(input logic [63:0] a);
      fits1 = (a < 64'(MemBytes));
   endfunction

   // evaluate a branch or move condition from Z,S,O
   function automatic logic cond_true(input logic [3:0] c, input logic [2:0] f);
      logic lt;
      logic z;
      lt = f[1] ^ f[0];
      z  = f[2];
      case (c)
         4'd0:    cond_true = 1'b1;
         4'd1:    cond_true = lt | z;
         4'd2:    cond_true = lt;
         4'd3:    cond_true = z;
         4'd4:    cond_true = !z;
         4'd5:    cond_true = !lt;
         default: cond_true = !lt && !z;
      endcase
   endfunction
endpackage
`default_nettype wire

// File: hw/rtl/y64_mem.sv
// Byte-wide main memory with a clearing pass after reset.
`default_nettype none
module y64_mem (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire y64_pkg::mem_req_type   req,
   input  wire logic                   req_en,
   output logic [7:0]                  rdata,
   output logic                        clr_busy
);
   import y64_pkg::*;

   logic [7:0]          mem [MemBytes];
   logic [AddrBits:0]   clr_ff;
   logic [AddrBits:0]   clr_in;

   // sweep every byte to zero after reset
   always_comb begin
      clr_in = clr_ff;
      if (!clr_ff[AddrBits]) clr_in = clr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else       clr_ff <= clr_in;
   end

   assign clr_busy = !clr_ff[AddrBits];

   // one registered read and at most one write a cycle; the clearing pass takes the write port
   always_ff @(posedge clock) begin
      if (clr_busy) begin
         mem[clr_ff[AddrBits-1:0]] <= 8'd0;
      end else if (req_en && req.wr) begin
         mem[req.addr] <= req.wdata;
      end
      rdata <= mem[req.addr];
   end
endmodule
`default_nettype wire

// File: hw/rtl/y64_alu.sv
// Shared 64-bit adder/logic unit with flag generation.
`default_nettype none
module y64_alu (
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   input  wire logic [1:0]  fn,
   output logic [63:0]      v,
   output logic [2:0]       flg
);
   logic o;
   // fn 0 b+a, 1 b-a, 2 and, 3 xor
   always_comb begin
      o = 1'b0;
      case (fn)
         2'd0: begin
            v = b + a;
            o = (~(a[63] ^ b[63])) & (v[63] ^ a[63]);
         end
         2'd1: begin
            v = b - a;
            o = (a[63] ^ b[63]) & (v[63] ^ b[63]);
         end
         2'd2: v = a & b;
         default: v = a ^ b;
      endcase
      flg = {v == 64'd0, v[63], o};
   end
endmodule
`default_nettype wire

// File: hw/rtl/y64_instruction_executor_core.sv
// Top level: sequencer, register file and result register of the Y86-64 executor.
//
//  channel | ports                                            | dir
//  req     | req_valid req_stall req_func req_mem_addr ...     | in
//  rsp     | rsp_valid rsp_stall rsp_status rsp_read_data ...  | out
//
// After reset, a clearing pass zeroes memory; req_stall is high while it runs.
// A byte write or register read goes from the accept straight to the response state;
// a byte read passes a wait state first. An execute spends a request state and a wait
// state on each byte fetched or loaded and a store state on each byte stored.
// One word is handled at a time; req_stall stays high until the result is taken,
// and rsp_stall holds the result in place while it is high.
`default_nettype none
module y64_instruction_executor_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [11:0] req_mem_addr,
   input  wire logic [7:0]  req_write_byte,
   input  wire logic [3:0]  req_reg_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [63:0]      rsp_read_data,
   output logic [63:0]      rsp_pc_now,
   output logic [2:0]       rsp_flags
);
   import y64_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RWAIT = 4'd1;
   localparam logic [3:0] S_F0    = 4'd2;
   localparam logic [3:0] S_F0W   = 4'd3;
   localparam logic [3:0] S_F1    = 4'd4;
   localparam logic [3:0] S_F1W   = 4'd5;
   localparam logic [3:0] S_IMM   = 4'd6;
   localparam logic [3:0] S_IMMW  = 4'd7;
   localparam logic [3:0] S_EXE   = 4'd8;
   localparam logic [3:0] S_ADDR  = 4'd9;
   localparam logic [3:0] S_LD    = 4'd10;
   localparam logic [3:0] S_LDW   = 4'd11;
   localparam logic [3:0] S_ST    = 4'd12;
   localparam logic [3:0] S_DONE  = 4'd13;
   localparam logic [3:0] S_RSP   = 4'd14;

   logic [3:0]  st_ff, st_in;
   logic [63:0] pc_ff, pc_in;
   logic [2:0]  flg_ff, flg_in;
   logic [63:0] rf_ff [15];
   logic        rf_we;
   logic [3:0]  rf_wa;
   logic [63:0] rf_wd;
   logic        rf2_we;
   logic [3:0]  rf2_wa;
   logic [63:0] rf2_wd;

   logic [3:0]  icode_ff, icode_in, ifn_ff, ifn_in, ra_ff, ra_in, rb_ff, rb_in;
   logic [63:0] np_ff, np_in, imm_ff, imm_in, addr_ff, addr_in, dat_ff, dat_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [1:0]  ost_ff, ost_in;
   logic [63:0] ord_ff, ord_in;

   mem_req_type mreq;
   logic        men;
   logic [7:0]  mrd;
   logic        clr_busy;

   logic [63:0] alu_a, alu_b, alu_v;
   logic [1:0]  alu_fn;
   logic [2:0]  alu_flg;

   y64_mem u_mem (
      .clock(clock), .reset(reset), .req(mreq), .req_en(men),
      .rdata(mrd), .clr_busy(clr_busy)
   );

   y64_alu u_alu (.a(alu_a), .b(alu_b), .fn(alu_fn), .v(alu_v), .flg(alu_flg));

   logic [63:0] rav, rbv, spv;
   logic        need_regs, need_imm;
   // register 15 reads as zero
   assign rav = (ra_ff == NO_REG) ? 64'd0 : rf_ff[ra_ff];
   assign rbv = (rb_ff == NO_REG) ? 64'd0 : rf_ff[rb_ff];
   assign spv = rf_ff[SP_REG];
   assign need_regs = (icode_ff == I_CMOV) || (icode_ff == I_IRMOV) ||
                      (icode_ff == I_RMMOV) || (icode_ff == I_MRMOV) ||
                      (icode_ff == I_OP) || (icode_ff == I_PUSH) || (icode_ff == I_POP);
   assign need_imm = (icode_ff == I_IRMOV) || (icode_ff == I_RMMOV) ||
                     (icode_ff == I_MRMOV) || (icode_ff == I_JXX) || (icode_ff == I_CALL);

   assign req_stall = (st_ff != S_IDLE) || clr_busy;
   assign rsp_valid = (st_ff == S_RSP);
   assign rsp_status = ost_ff;
   assign rsp_read_data = ord_ff;
   assign rsp_pc_now = pc_ff;
   assign rsp_flags = flg_ff;

   // sequencer: fetch, decode, one byte of memory traffic per step
   always_comb begin
      st_in = st_ff; pc_in = pc_ff; flg_in = flg_ff;
      icode_in = icode_ff; ifn_in = ifn_ff;
      ra_in = ra_ff; rb_in = rb_ff; np_in = np_ff; imm_in = imm_ff;
      addr_in = addr_ff; dat_in = dat_ff; cnt_in = cnt_ff;
      ost_in = ost_ff; ord_in = ord_ff;
      rf_we = 1'b0; rf_wa = NO_REG; rf_wd = '0;
      rf2_we = 1'b0; rf2_wa = NO_REG; rf2_wd = '0;
      mreq.wr = 1'b0; mreq.addr = addr_ff[AddrBits-1:0]; mreq.wdata = dat_ff[7:0];
      men = 1'b0;
      alu_a = rav; alu_b = rbv; alu_fn = ifn_ff[1:0];

      unique case (st_ff)
         S_IDLE: begin
            if (req_valid && !clr_busy) begin
               ost_in = ST_AOK;
               ord_in = '0;
               mreq.addr = req_mem_addr;
               unique case (req_func)
                  FUNC_WR_MEM: begin
                     mreq.wr = 1'b1; mreq.wdata = req_write_byte; men = 1'b1;
                     st_in = S_RSP;
                  end
                  FUNC_RD_MEM: st_in = S_RWAIT;
                  FUNC_EXEC: begin
                     np_in = pc_ff;
                     st_in = S_F0;
                  end
                  default: begin
                     ord_in = (req_reg_index == NO_REG) ? 64'd0 : rf_ff[req_reg_index];
                     st_in = S_RSP;
                  end
               endcase
            end
         end
         S_RWAIT: begin
            ord_in = {56'd0, mrd};
            st_in = S_RSP;
         end
         S_F0: begin
            if (!fits1(np_ff)) begin
               ost_in = ST_ADR; st_in = S_RSP;
            end else begin
               mreq.addr = np_ff[AddrBits-1:0];
               st_in = S_F0W;
            end
         end
         S_F0W: begin
            icode_in = mrd[7:4]; ifn_in = mrd[3:0];
            ra_in = NO_REG; rb_in = NO_REG;
            np_in = np_ff + 64'd1;
            st_in = S_F1;
         end
         S_F1: begin
            if (!need_regs) begin
               st_in = S_IMM; cnt_in = '0;
            end else if (!fits1(np_ff)) begin
               ost_in = ST_ADR; st_in = S_RSP;
            end else begin
               mreq.addr = np_ff[AddrBits-1:0];
               st_in = S_F1W;
            end
         end
         S_F1W: begin
            ra_in = mrd[7:4]; rb_in = mrd[3:0];
            np_in = np_ff + 64'd1;
            cnt_in = '0;
            st_in = S_IMM;
         end
         S_IMM: begin
            if (!need_imm) begin
               st_in = S_EXE;
            end else if (cnt_ff == 3'd0 && !fits8(np_ff)) begin
               ost_in = ST_ADR; st_in = S_RSP;
            end else begin
               mreq.addr = np_ff[AddrBits-1:0] + AddrBits'(cnt_ff);
               st_in = S_IMMW;
            end
         end
         S_IMMW: begin
            imm_in = {mrd, imm_ff[63:8]};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               np_in = np_ff + 64'd8;
               st_in = S_EXE;
            end else begin
               st_in = S_IMM;
            end
         end
         S_EXE: begin
            st_in = S_DONE;
            cnt_in = '0;
            case (icode_ff)
               I_HALT: begin ost_in = ST_HLT; st_in = S_RSP; end
               I_NOP: ;
               I_CMOV: begin
                  if (ifn_ff > 4'd6) begin ost_in = ST_INS; st_in = S_RSP; end
                  else if (cond_true(ifn_ff, flg_ff)) begin
                     rf_we = 1'b1; rf_wa = rb_ff; rf_wd = rav;
                  end
               end
               I_IRMOV: begin rf_we = 1'b1; rf_wa = rb_ff; rf_wd = imm_ff; end
               I_RMMOV, I_MRMOV: begin
                  alu_a = imm_ff; alu_b = rbv; alu_fn = 2'd0;
                  addr_in = alu_v; dat_in = rav;
                  st_in = S_ADDR;
               end
               I_OP: begin
                  if (ifn_ff > 4'd3) begin ost_in = ST_INS; st_in = S_RSP; end
                  else begin
                     flg_in = alu_flg;
                     rf_we = 1'b1; rf_wa = rb_ff; rf_wd = alu_v;
                  end
               end
               I_JXX: begin
                  if (ifn_ff > 4'd6) begin ost_in = ST_INS; st_in = S_RSP; end
                  else if (cond_true(ifn_ff, flg_ff)) np_in = imm_ff;
               end
               I_CALL, I_PUSH: begin
                  alu_a = 64'd8; alu_b = spv; alu_fn = 2'd1;
                  addr_in = alu_v;
                  dat_in = (icode_ff == I_CALL) ? np_ff : rav;
                  st_in = S_ADDR;
               end
               I_RET, I_POP: begin
                  addr_in = spv; st_in = S_ADDR;
               end
               default: begin ost_in = ST_INS; st_in = S_RSP; end
            endcase
         end
         S_ADDR: begin
            if (!fits8(addr_ff)) begin
               ost_in = ST_ADR; st_in = S_RSP;
            end else if (icode_ff == I_MRMOV || icode_ff == I_RET ||
                         icode_ff == I_POP) begin
               st_in = S_LD;
            end else begin
               st_in = S_ST;
            end
         end
         S_ST: begin
            mreq.wr = 1'b1; men = 1'b1;
            mreq.addr = addr_ff[AddrBits-1:0] + AddrBits'(cnt_ff);
            dat_in = {8'd0, dat_ff[63:8]};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               if (icode_ff == I_CALL) begin
                  rf_we = 1'b1; rf_wa = SP_REG; rf_wd = addr_ff; np_in = imm_ff;
               end else if (icode_ff == I_PUSH) begin
                  rf_we = 1'b1; rf_wa = SP_REG; rf_wd = addr_ff;
               end
               st_in = S_DONE;
            end
         end
         S_LD: begin
            mreq.addr = addr_ff[AddrBits-1:0] + AddrBits'(cnt_ff);
            st_in = S_LDW;
         end
         S_LDW: begin
            dat_in = {mrd, dat_ff[63:8]};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               alu_a = 64'd8; alu_b = addr_ff; alu_fn = 2'd0;
               if (icode_ff == I_MRMOV) begin
                  rf_we = 1'b1; rf_wa = ra_ff; rf_wd = {mrd, dat_ff[63:8]};
               end else if (icode_ff == I_RET) begin
                  rf_we = 1'b1; rf_wa = SP_REG; rf_wd = alu_v;
                  np_in = {mrd, dat_ff[63:8]};
               end else begin
                  rf_we = 1'b1; rf_wa = SP_REG; rf_wd = alu_v;
                  rf2_we = 1'b1; rf2_wa = ra_ff; rf2_wd = {mrd, dat_ff[63:8]};
               end
               st_in = S_DONE;
            end else begin
               st_in = S_LD;
            end
         end
         S_DONE: begin
            pc_in = np_ff; st_in = S_RSP;
         end
         S_RSP: begin
            if (!rsp_stall) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   // control and architectural state; the popped value wins over the stack pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         pc_ff <= '0;
         flg_ff <= 3'b100;
         for (int i = 0; i < 15; i++) rf_ff[i] <= '0;
      end else begin
         st_ff <= st_in;
         pc_ff <= pc_in;
         flg_ff <= flg_in;
         if (rf_we && rf_wa != NO_REG && !(rf2_we && rf2_wa == rf_wa))
            rf_ff[rf_wa] <= rf_wd;
         if (rf2_we && rf2_wa != NO_REG) rf_ff[rf2_wa] <= rf2_wd;
      end
   end

   // working registers of the current word
   always_ff @(posedge clock) begin
      icode_ff <= icode_in; ifn_ff <= ifn_in;
      ra_ff <= ra_in; rb_ff <= rb_in; np_ff <= np_in; imm_ff <= imm_in;
      addr_ff <= addr_in; dat_ff <= dat_in; cnt_ff <= cnt_in;
      ost_ff <= ost_in; ord_ff <= ord_in;
   end
endmodule
`default_nettype wire
